// ----- rtl/mwsf_pkg.sv -----
`timescale 1ns / 1ps

package mwsf_pkg;

  localparam int NUM_GAMES = 256;
  localparam int PLAN_DAYS = 365;

  localparam int GAME_W   = 8;
  localparam int RATING_W = 16;
  localparam int WIN_W    = 9;
  localparam int START_W  = 9;
  localparam int SUM_W    = 25;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(7);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DAY  = 1'b1;

  localparam int GAME_AW = (NUM_GAMES > 1) ? $clog2(NUM_GAMES) : 1;
  localparam int SLOT_W  = (PLAN_DAYS > 1) ? $clog2(PLAN_DAYS) : 1;
  localparam int DAY_W   = $clog2(PLAN_DAYS + 1);
  localparam int CW      = ((DAY_W > WIN_W) ? DAY_W : WIN_W) + 1;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic                is_day;
    logic                game_ok;
    logic [GAME_AW-1:0]  game_addr;
    logic [RATING_W-1:0] rating;
    logic                last;
    logic                counted;
    logic                has_leave;
    logic                check;
    logic [SLOT_W-1:0]   slot;
    logic [SLOT_W-1:0]   leave_slot;
    logic [START_W-1:0]  start;
  } entry_t;

endpackage

// ----- rtl/mwsf_ram.sv -----
`timescale 1ns / 1ps

module mwsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mwsf_front.sv -----
`timescale 1ns / 1ps

module mwsf_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [mwsf_pkg::GAME_W-1:0]    in_game,
  input  logic [mwsf_pkg::RATING_W-1:0]  in_rating,
  input  logic                           in_last,
  input  logic [mwsf_pkg::WIN_W-1:0]     window_days,
  input  logic                           q_ready,
  output logic                           q_push,
  output mwsf_pkg::entry_t               q_entry
);

  logic [mwsf_pkg::DAY_W-1:0] day_r, day_nxt;
  logic [mwsf_pkg::CW-1:0]    dayc;
  logic [mwsf_pkg::CW-1:0]    wc;
  logic                       is_day;
  logic                       counted;

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;
  assign is_day   = (in_cmd == mwsf_pkg::CMD_DAY);
  assign counted  = day_r < mwsf_pkg::DAY_W'(mwsf_pkg::PLAN_DAYS);
  assign dayc     = mwsf_pkg::CW'(day_r) + mwsf_pkg::CW'(1);
  assign wc       = mwsf_pkg::CW'(window_days);

  always_comb begin
    q_entry            = '0;
    q_entry.is_day     = is_day;
    q_entry.game_ok    = 32'(in_game) < 32'(mwsf_pkg::NUM_GAMES);
    q_entry.game_addr  = mwsf_pkg::GAME_AW'(32'(in_game));
    q_entry.rating     = in_rating;
    q_entry.last       = in_last && is_day;
    q_entry.counted    = counted;
    q_entry.has_leave  = (window_days != '0) && (dayc > wc);
    q_entry.check      = (window_days != '0) && (wc <= mwsf_pkg::CW'(mwsf_pkg::PLAN_DAYS))
                         && (dayc >= wc);
    q_entry.slot       = mwsf_pkg::SLOT_W'(day_r);
    q_entry.leave_slot = mwsf_pkg::SLOT_W'(dayc - wc - mwsf_pkg::CW'(1));
    q_entry.start      = mwsf_pkg::START_W'(dayc - wc + mwsf_pkg::CW'(1));
  end

  always_comb begin
    day_nxt = day_r;
    if (q_push && is_day) begin
      if (in_last) begin
        day_nxt = '0;
      end else if (counted) begin
        day_nxt = mwsf_pkg::DAY_W'(dayc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r <= '0;
    end else begin
      day_r <= day_nxt;
    end
  end

endmodule

// ----- rtl/mwsf_queue.sv -----
`timescale 1ns / 1ps

module mwsf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mwsf_pkg::entry_t push_entry,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output mwsf_pkg::entry_t pop_entry
);

  mwsf_pkg::entry_t              mem_r [mwsf_pkg::QDEPTH];
  logic [mwsf_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [mwsf_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [mwsf_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          do_pop;

  assign push_ready = cnt_r != mwsf_pkg::QCNT_W'(mwsf_pkg::QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == mwsf_pkg::QPTR_W'(mwsf_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + mwsf_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == mwsf_pkg::QPTR_W'(mwsf_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + mwsf_pkg::QPTR_W'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + mwsf_pkg::QCNT_W'(1);
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - mwsf_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/mwsf_back.sv -----
`timescale 1ns / 1ps

module mwsf_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  mwsf_pkg::entry_t               q_entry,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mwsf_pkg::START_W-1:0]   out_best_start,
  output logic [mwsf_pkg::SUM_W-1:0]     out_best_sum
);

  logic                           adv;
  logic                           pop;

  // rating table and window delay line
  logic                           rt_we, rt_re;
  logic [mwsf_pkg::RATING_W-1:0]  rt_rdata;
  logic                           wl_we, wl_re;
  logic [mwsf_pkg::RATING_W-1:0]  wl_rdata;

  // stage 1: ram data
  logic                           s1_valid_r, s1_valid_nxt;
  mwsf_pkg::entry_t               s1_r;
  logic                           byp_hit_r;
  logic [mwsf_pkg::RATING_W-1:0]  byp_data_r;
  logic [mwsf_pkg::RATING_W-1:0]  r1;
  logic [mwsf_pkg::RATING_W-1:0]  leave1;
  logic [mwsf_pkg::SUM_W-1:0]     new_sum;
  logic [mwsf_pkg::SUM_W-1:0]     sum_r, sum_nxt;

  // stage 2: compare against best
  logic                           s2_valid_r, s2_valid_nxt;
  logic                           s2_last_r;
  logic                           s2_check_r;
  logic [mwsf_pkg::SUM_W-1:0]     s2_sum_r;
  logic [mwsf_pkg::START_W-1:0]   s2_start_r;
  logic                           upd;
  logic [mwsf_pkg::SUM_W-1:0]     cand_sum;
  logic [mwsf_pkg::START_W-1:0]   cand_start;
  logic [mwsf_pkg::SUM_W-1:0]     top_sum_r, top_sum_nxt;
  logic [mwsf_pkg::START_W-1:0]   top_start_r, top_start_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic                           res_fire;

  assign adv   = !(s2_valid_r && s2_last_r && out_valid_r && !out_ready);
  assign pop   = adv && q_valid;
  assign q_pop = pop;

  assign rt_we = pop && !q_entry.is_day && q_entry.game_ok;
  assign rt_re = pop && q_entry.is_day && q_entry.counted;

  mwsf_ram #(
    .WIDTH (mwsf_pkg::RATING_W),
    .DEPTH (mwsf_pkg::NUM_GAMES)
  ) u_rating_ram (
    .clk   (clk),
    .we    (rt_we),
    .waddr (q_entry.game_addr),
    .wdata (q_entry.rating),
    .re    (rt_re),
    .raddr (q_entry.game_addr),
    .rdata (rt_rdata)
  );

  assign r1    = s1_r.game_ok ? rt_rdata : '0;
  assign wl_we = adv && s1_valid_r && s1_r.counted;
  assign wl_re = pop && q_entry.is_day && q_entry.counted && q_entry.has_leave;

  mwsf_ram #(
    .WIDTH (mwsf_pkg::RATING_W),
    .DEPTH (mwsf_pkg::PLAN_DAYS)
  ) u_window_ram (
    .clk   (clk),
    .we    (wl_we),
    .waddr (s1_r.slot),
    .wdata (r1),
    .re    (wl_re),
    .raddr (q_entry.leave_slot),
    .rdata (wl_rdata)
  );

  assign leave1  = s1_r.has_leave ? (byp_hit_r ? byp_data_r : wl_rdata) : '0;
  assign new_sum = sum_r + mwsf_pkg::SUM_W'(r1) - mwsf_pkg::SUM_W'(leave1);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    sum_nxt      = sum_r;
    s2_valid_nxt = s2_valid_r;
    if (adv) begin
      s1_valid_nxt = pop && q_entry.is_day;
      s2_valid_nxt = s1_valid_r;
      if (s1_valid_r) begin
        if (s1_r.last) begin
          sum_nxt = '0;
        end else if (s1_r.counted) begin
          sum_nxt = new_sum;
        end
      end
    end
  end

  assign upd        = s2_check_r && ((top_start_r == '0) || (s2_sum_r > top_sum_r));
  assign cand_sum   = upd ? s2_sum_r : top_sum_r;
  assign cand_start = upd ? s2_start_r : top_start_r;
  assign res_fire   = adv && s2_valid_r && s2_last_r;

  always_comb begin
    top_sum_nxt   = top_sum_r;
    top_start_nxt = top_start_r;
    if (adv && s2_valid_r) begin
      if (s2_last_r) begin
        top_sum_nxt   = '0;
        top_start_nxt = '0;
      end else begin
        top_sum_nxt   = cand_sum;
        top_start_nxt = cand_start;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_r       <= q_entry;
      byp_hit_r  <= wl_we && (s1_r.slot == q_entry.leave_slot);
      byp_data_r <= r1;
    end
    if (adv) begin
      s2_last_r  <= s1_r.last;
      s2_check_r <= s1_r.counted && s1_r.check;
      s2_sum_r   <= new_sum;
      s2_start_r <= s1_r.start;
    end
    if (res_fire) begin
      out_best_start <= cand_start;
      out_best_sum   <= cand_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      sum_r       <= '0;
      top_sum_r   <= '0;
      top_start_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      sum_r       <= sum_nxt;
      top_sum_r   <= top_sum_nxt;
      top_start_r <= top_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/max_window_sum_finder.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// in        in   in_valid / in_ready    in_cmd, in_game, in_rating, in_last
// out       out  out_valid / out_ready  out_best_start, out_best_sum
// cfg       in   cfg_valid / cfg_ready  cfg_data (window length in days)
//
// one item per cycle unless stalled; results reach out_valid via the queue, stage 1 and stage 2
// the back end runs a rating ram read, a window ram read and an add/subtract on the running sum
// back end stalls only when a second result meets a full output register; the held stages take no
// more, the two-entry queue takes up to two more items, then in_ready drops until out_ready rises
// synchronous active-low reset clears control state; window length resets to 7 days

module max_window_sum_finder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [mwsf_pkg::GAME_W-1:0]    in_game,
  input  logic [mwsf_pkg::RATING_W-1:0]  in_rating,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mwsf_pkg::START_W-1:0]   out_best_start,
  output logic [mwsf_pkg::SUM_W-1:0]     out_best_sum,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mwsf_pkg::WIN_W-1:0]     cfg_data
);

  logic [mwsf_pkg::WIN_W-1:0] win_days_r, win_days_nxt;
  logic                       q_ready;
  logic                       q_push;
  mwsf_pkg::entry_t           push_entry;
  logic                       q_valid;
  logic                       q_pop;
  mwsf_pkg::entry_t           pop_entry;

  assign cfg_ready    = 1'b1;
  assign win_days_nxt = (cfg_valid && cfg_ready) ? cfg_data : win_days_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_days_r <= mwsf_pkg::WIN_RESET;
    end else begin
      win_days_r <= win_days_nxt;
    end
  end

  mwsf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_game     (in_game),
    .in_rating   (in_rating),
    .in_last     (in_last),
    .window_days (win_days_r),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_entry     (push_entry)
  );

  mwsf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (pop_entry)
  );

  mwsf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_entry        (pop_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_best_start (out_best_start),
    .out_best_sum   (out_best_sum)
  );

  a_no_out_after_reset : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_empty_start_zero_sum : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_best_start == '0)) |-> (out_best_sum == '0))
    else $error("nonzero sum reported without a fitting window");

  a_start_in_plan : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_best_start) <= 32'(mwsf_pkg::PLAN_DAYS)))
    else $error("best start beyond plan length");

endmodule
